[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/hpd_pkg.sv]
// ----------------------------------------------------------------------------
// hpd_pkg
// Types, codes and helper functions of the hold-and-modify pixel decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int unsigned COLOR_W = 24;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DEPTH   = 256;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_PLAIN = 2'd0,
        MODE_HAM6  = 2'd1,
        MODE_HAM8  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SEL_TABLE = 2'd0,
        SEL_BLUE  = 2'd1,
        SEL_RED   = 2'd2,
        SEL_GREEN = 2'd3
    } t_sel;

    typedef struct packed {
        t_mode  mode;
        t_pixel pixel;
        logic   row_start;
        t_color base;
    } t_stage;

    function automatic t_index table_addr(input t_mode mode, input t_pixel pixel);
        t_index addr;
        case (mode)
            MODE_HAM6: addr = {4'b0000, pixel[3:0]};
            MODE_HAM8: addr = {2'b00, pixel[5:0]};
            default:   addr = pixel;
        endcase
        return addr;
    endfunction

    function automatic t_color merge(input t_sel sel, input t_color start,
                                     input t_color entry, input logic [7:0] value);
        t_color res;
        unique case (sel)
            SEL_TABLE: res = entry;
            SEL_BLUE:  res = {start[23:8], value};
            SEL_RED:   res = {value, start[15:0]};
            SEL_GREEN: res = {start[23:16], value, start[7:0]};
            default:   res = entry;
        endcase
        return res;
    endfunction

endpackage

[design/hpd_if.sv]
// ----------------------------------------------------------------------------
// hpd_in_if and hpd_out_if
// Valid/ready channels for input items and decoded colors.
// ----------------------------------------------------------------------------
interface hpd_in_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    hpd_pkg::t_index       palette_index;
    hpd_pkg::t_color       palette_color;
    hpd_pkg::t_pixel       pixel_value;
    logic                  row_start;

    modport source (output valid, command, palette_index, palette_color, pixel_value,
                    row_start, input ready);
    modport sink (input valid, command, palette_index, palette_color, pixel_value,
                  row_start, output ready);
endinterface

interface hpd_out_if;
    logic            valid;
    logic            ready;
    hpd_pkg::t_color rgb_color;

    modport source (output valid, rgb_color, input ready);
    modport sink (input valid, rgb_color, output ready);
endinterface

[design/hpd_table.sv]
// ----------------------------------------------------------------------------
// hpd_table
// Color table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hpd_table (
    input  logic            i_clk,
    input  logic            i_we,
    input  hpd_pkg::t_index i_waddr,
    input  hpd_pkg::t_color i_wdata,
    input  logic            i_re,
    input  hpd_pkg::t_index i_raddr,
    output hpd_pkg::t_color o_rdata
);

    hpd_pkg::t_color r_mem [hpd_pkg::DEPTH];
    hpd_pkg::t_color r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/ham_palette_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// ham_palette_pixel_decoder
// Decodes palette and hold-and-modify pixels into 24-bit RGB colors.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transfer carries
//  i_pix      in         table load or pixel decode item
//  o_rgb      out        decoded color, one per decode item
//  i_cfg_*    in         display mode register write
//
//  One item per cycle while i_pix.ready is high. The table read port and the
//  decode stage register the pixel together, and the held-color merge then
//  feeds the output register, from which the color transfers on o_rgb.
//  Reset clears the held color, the entry-zero copy and the mode; the table
//  itself is not cleared. A stalled output holds the decode stage, and input
//  transfers stop only while both the stage and the output register are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ham_palette_pixel_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hpd_in_if.sink        i_pix,
    hpd_out_if.source     o_rgb,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data
);

    hpd_pkg::t_mode  r_mode;
    hpd_pkg::t_color r_zero_copy;
    hpd_pkg::t_color r_held;
    hpd_pkg::t_color n_held;
    logic            r_s1_valid;
    hpd_pkg::t_stage r_s1;
    logic            r_out_valid;
    hpd_pkg::t_color r_out_color;
    hpd_pkg::t_color n_out_color;
    hpd_pkg::t_color table_data;
    hpd_pkg::t_color start;
    hpd_pkg::t_sel   sel;
    logic [7:0]      value;
    logic            s1_adv;
    logic            in_xfer;
    logic            load_xfer;
    logic            decode_xfer;
    logic            zero_load;
    logic            full_stall;

    assign s1_adv      = !r_out_valid || o_rgb.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_xfer     = i_pix.valid && i_pix.ready;
    assign load_xfer   = in_xfer && (i_pix.command == hpd_pkg::CMD_LOAD);
    assign decode_xfer = in_xfer && (i_pix.command == hpd_pkg::CMD_DECODE);
    assign zero_load   = load_xfer && (i_pix.palette_index == '0);
    assign full_stall  = r_s1_valid && r_out_valid && !o_rgb.ready;

    hpd_table u_table (
        .i_clk   (i_clk),
        .i_we    (load_xfer),
        .i_waddr (i_pix.palette_index),
        .i_wdata (i_pix.palette_color),
        .i_re    (decode_xfer),
        .i_raddr (hpd_pkg::table_addr(r_mode, i_pix.pixel_value)),
        .o_rdata (table_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hpd_pkg::MODE_PLAIN;
        end else if (i_cfg_we) begin
            r_mode <= hpd_pkg::t_mode'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_copy <= '0;
        end else if (zero_load) begin
            r_zero_copy <= i_pix.palette_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= decode_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decode_xfer) begin
            r_s1.mode      <= r_mode;
            r_s1.pixel     <= i_pix.pixel_value;
            r_s1.row_start <= i_pix.row_start;
            r_s1.base      <= r_zero_copy;
        end
    end

    always_comb begin
        start = r_s1.row_start ? r_s1.base : r_held;
        case (r_s1.mode)
            hpd_pkg::MODE_HAM6: begin
                sel   = hpd_pkg::t_sel'(r_s1.pixel[5:4]);
                value = {r_s1.pixel[3:0], r_s1.pixel[3:0]};
            end
            hpd_pkg::MODE_HAM8: begin
                sel   = hpd_pkg::t_sel'(r_s1.pixel[7:6]);
                value = {r_s1.pixel[5:0], r_s1.pixel[5:4]};
            end
            default: begin
                sel   = hpd_pkg::SEL_TABLE;
                value = '0;
            end
        endcase
        if (r_s1.mode == hpd_pkg::MODE_HAM6 || r_s1.mode == hpd_pkg::MODE_HAM8) begin
            n_held      = hpd_pkg::merge(sel, start, table_data, value);
            n_out_color = n_held;
        end else begin
            n_held      = start;
            n_out_color = table_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_s1_valid && s1_adv) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_color <= n_out_color;
        end
    end

    assign o_rgb.valid     = r_out_valid;
    assign o_rgb.rgb_color = r_out_color;

    `ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, full_stall, r_s1_valid)
    `ASSERT_NEXT(a_decode_enters, i_clk, i_rst_n, decode_xfer, r_s1_valid)
    `ASSERT_NEXT(a_zero_copy, i_clk, i_rst_n, zero_load, r_zero_copy == $past(i_pix.palette_color))
    `ASSERT_SAME(a_no_decode_when_full, i_clk, i_rst_n, full_stall, !in_xfer)

endmodule
